/* rtl/ptw_pkg.sv */
package ptw_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int INDEX_BITS = 9;
  localparam int VA_W       = 64;
  localparam int ENTRY_W    = 64;
  localparam int ADDR_W     = 52;
  localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
  localparam int ARM_FRAME_W = 38;
  localparam int LEVEL_W    = 3;
  localparam int CFG_DATA_W = ADDR_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LEVEL_W-1:0] LVL_NONE = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_PT   = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_PD   = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_PDPT = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_TOP4 = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_TOP5 = 3'd5;

  localparam int X64_LARGE_BIT = 7;
  localparam int ARM_BLOCK_BIT = 1;
  localparam int VALID_BIT     = 0;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_FAULT   = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_ROOT    = 2'd0,
    REG_ARCH_MODE     = 2'd1,
    REG_PAGING_LEVELS = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PSZ_4K = 2'd0,
    PSZ_2M = 2'd1,
    PSZ_1G = 2'd2
  } psz_t;

  localparam logic ARCH_X64 = 1'b0;

  typedef struct packed {
    logic              action;
    logic [VA_W-1:0]   virt_addr;
    logic [ENTRY_W-1:0] entry_data;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [LEVEL_W-1:0] fault_level;
    psz_t               page_size;
    logic               identity_map;
  } result_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  table_root;
    logic               arch_mode;
    logic [LEVEL_W-1:0] paging_levels;
  } cfg_t;

  typedef struct packed {
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic [VA_W-1:0]    saved_vaddr;
  } walk_t;

  function automatic logic [INDEX_BITS-1:0] level_index(input logic [VA_W-1:0] va,
                                                        input logic [LEVEL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] idx;
    case (lvl) inside
      LVL_NONE, LVL_PT: idx = va[PAGE_SHIFT +: INDEX_BITS];
      LVL_PD:           idx = va[PAGE_SHIFT + INDEX_BITS +: INDEX_BITS];
      LVL_PDPT:         idx = va[PAGE_SHIFT + 2*INDEX_BITS +: INDEX_BITS];
      LVL_TOP4:         idx = va[PAGE_SHIFT + 3*INDEX_BITS +: INDEX_BITS];
      default:          idx = va[PAGE_SHIFT + 4*INDEX_BITS +: INDEX_BITS];
    endcase
    return idx;
  endfunction

endpackage

/* rtl/ptw_req_if.sv */
interface ptw_req_if import ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [VA_W-1:0]    virt_addr;
  logic [ENTRY_W-1:0] entry_data;

  modport source (output valid, action, virt_addr, entry_data, input ready);
  modport sink   (input valid, action, virt_addr, entry_data, output ready);
endinterface

/* rtl/ptw_rsp_if.sv */
interface ptw_rsp_if import ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [ADDR_W-1:0]  address;
  logic [LEVEL_W-1:0] fault_level;
  logic [1:0]         page_size;
  logic               identity_map;

  modport source (output valid, kind, address, fault_level, page_size, identity_map,
                  input ready);
  modport sink   (input valid, kind, address, fault_level, page_size, identity_map,
                  output ready);
endinterface

/* rtl/ptw_step.sv */
module ptw_step import ptw_pkg::*; (
  input  item_t   item,
  input  walk_t   walk,
  input  cfg_t    cfg,
  output result_t res,
  output walk_t   walk_next
);

  logic [ADDR_W-1:0]          base;
  logic [LEVEL_W-1:0]         start_level;
  logic [LEVEL_W-1:0]         down_level;
  logic [FRAME_W-1:0]         frame;
  logic                       big_page;
  logic [INDEX_BITS-1:0]      pd_idx;
  logic [INDEX_BITS-1:0]      pt_idx;
  logic [FRAME_W-1:0]         pfn;
  logic [ADDR_W-1:0]          pa;

  assign base   = {cfg.table_root[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign pd_idx = level_index(walk.saved_vaddr, LVL_PD);
  assign pt_idx = level_index(walk.saved_vaddr, LVL_PT);
  assign start_level = (cfg.arch_mode == ARCH_X64 && cfg.paging_levels == LVL_TOP5) ?
                       LVL_TOP5 : LVL_TOP4;
  assign down_level  = walk.level - LVL_PT;

  always_comb begin
    if (cfg.arch_mode == ARCH_X64) begin
      frame    = item.entry_data[PAGE_SHIFT +: FRAME_W];
      big_page = item.entry_data[X64_LARGE_BIT];
    end else begin
      frame    = FRAME_W'(item.entry_data[PAGE_SHIFT +: ARM_FRAME_W]);
      big_page = !item.entry_data[ARM_BLOCK_BIT];
    end
  end

  always_comb begin
    if (walk.level == LVL_PDPT) begin
      pfn = frame + FRAME_W'({pd_idx, pt_idx});
    end else if (walk.level == LVL_PD) begin
      pfn = frame + FRAME_W'(pt_idx);
    end else begin
      pfn = frame;
    end
  end

  assign pa = {pfn, walk.saved_vaddr[PAGE_SHIFT-1:0]};

  always_comb begin
    res       = '{kind: KIND_IGNORED, address: '0, fault_level: '0,
                  page_size: PSZ_4K, identity_map: 1'b0};
    walk_next = walk;
    if (!item.action) begin
      walk_next.saved_vaddr = item.virt_addr;
      if (base == '0) begin
        res.kind        = KIND_FAULT;
        walk_next.busy  = 1'b0;
        walk_next.level = LVL_NONE;
      end else begin
        res.kind        = KIND_READ;
        res.address     = {base[ADDR_W-1:PAGE_SHIFT],
                           level_index(item.virt_addr, start_level), 3'b000};
        walk_next.busy  = 1'b1;
        walk_next.level = start_level;
      end
    end else if (walk.busy) begin
      if (!item.entry_data[VALID_BIT]) begin
        res.kind        = KIND_FAULT;
        res.fault_level = walk.level;
        walk_next.busy  = 1'b0;
        walk_next.level = LVL_NONE;
      end else if ((big_page && (walk.level == LVL_PDPT || walk.level == LVL_PD))
                   || walk.level <= LVL_PT) begin
        res.kind         = KIND_DONE;
        res.address      = pa;
        res.identity_map = (walk.saved_vaddr[VA_W-1:ADDR_W] == '0) &&
                           (pa == walk.saved_vaddr[ADDR_W-1:0]);
        if (walk.level == LVL_PDPT) begin
          res.page_size = PSZ_1G;
        end else if (walk.level == LVL_PD) begin
          res.page_size = PSZ_2M;
        end
        walk_next.busy  = 1'b0;
        walk_next.level = LVL_NONE;
      end else begin
        res.kind        = KIND_READ;
        res.address     = {frame, level_index(walk.saved_vaddr, down_level), 3'b000};
        walk_next.level = down_level;
      end
    end
  end

endmodule

/* rtl/page_table_walker.sv */
// Page-table walker for x64 (4 or 5 levels) and arm64 (4 levels) entries.
// Configuration: write table_root, arch_mode and paging_levels through the
// cfg_we / cfg_index / cfg_data port while no walk is in flight.
// Request channel (req): action 0 starts a walk of virt_addr, action 1
// returns the entry read for the last read request.
// Response channel (rsp): one item per request item - a read request with
// the entry address, a finished translation, a fault with its level, or a
// note that entry data arrived while idle.
// Path: a request item accepted into the input register gives its response
// on rsp once it moves on into the response register.
// Throughput: one item per cycle while rsp is not stalled; the input
// register and the response register form a two-stage pipeline and the
// walk state updates as an item leaves the input register, so the next
// item sees it at once. A stalled rsp holds its item; the input register
// still fills, then req.ready drops until rsp drains.
// Reset (rst, synchronous): pipeline empty, walk idle, table_root 0,
// arch_mode 0, paging_levels 4.
module page_table_walker import ptw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ptw_req_if.sink              req,
  ptw_rsp_if.source            rsp
);

  cfg_t    cfg;
  walk_t   walk;
  walk_t   walk_next;
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_adv;
  logic    out_valid;
  result_t out_res;
  result_t res;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{table_root: '0, arch_mode: ARCH_X64, paging_levels: LVL_TOP4};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TABLE_ROOT:    cfg.table_root    <= cfg_data;
        REG_ARCH_MODE:     cfg.arch_mode     <= cfg_data[0];
        REG_PAGING_LEVELS: cfg.paging_levels <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= '{action: req.action, virt_addr: req.virt_addr,
                   entry_data: req.entry_data};
    end
  end

  ptw_step u_step (
    .item      (s1_item),
    .walk      (walk),
    .cfg       (cfg),
    .res       (res),
    .walk_next (walk_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '{busy: 1'b0, level: LVL_NONE, saved_vaddr: '0};
    end else if (s1_adv) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_res.kind;
  assign rsp.address      = out_res.address;
  assign rsp.fault_level  = out_res.fault_level;
  assign rsp.page_size    = out_res.page_size;
  assign rsp.identity_map = out_res.identity_map;

endmodule

/* rtl/ptw_checker.sv */
module ptw_checker import ptw_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         rsp_kind,
  input logic [ADDR_W-1:0]  rsp_address,
  input logic [LEVEL_W-1:0] rsp_fault_level,
  input logic [1:0]         rsp_page_size,
  input logic               rsp_identity_map
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_READ |->
      rsp_fault_level == LVL_NONE && rsp_page_size == PSZ_4K && !rsp_identity_map)
    else $error("read request carries translation fields");

  a_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == KIND_FAULT || rsp_kind == KIND_IGNORED) |->
      rsp_address == '0 && rsp_page_size == PSZ_4K && !rsp_identity_map)
    else $error("fault or ignored item carries an address");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_fault_level <= LVL_TOP5 && rsp_page_size != 2'd3)
    else $error("fault level or page size out of range");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_kind         (rsp.kind),
  .rsp_address      (rsp.address),
  .rsp_fault_level  (rsp.fault_level),
  .rsp_page_size    (rsp.page_size),
  .rsp_identity_map (rsp.identity_map)
);
